/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tsd_pkg.sv */
// Shared types, constants and helpers of the tar stream deframer.
package tsd_pkg;

  localparam int unsigned OFFSET_W   = 9;
  localparam int unsigned BYTE_SUM_W = 17;
  localparam int unsigned SIZE_W     = 36;
  localparam int unsigned CSUM_W     = 24;

  localparam logic [OFFSET_W-1:0] BLOCK_LAST = 9'd511;
  localparam logic [OFFSET_W-1:0] SUM_FIRST  = 9'd148;
  localparam logic [OFFSET_W-1:0] SUM_LAST   = 9'd155;
  localparam logic [OFFSET_W-1:0] SIZE_FIRST = 9'd124;
  localparam logic [OFFSET_W-1:0] SIZE_LAST  = 9'd135;  // twelve bytes from SIZE_FIRST
  localparam logic [OFFSET_W-1:0] TYPE_AT    = 9'd156;

  localparam logic [7:0] SUM_FILL = 8'h20;
  localparam logic [7:0] DIR_TYPE = 8'h35;
  localparam logic [7:0] DIGIT_0  = 8'h30;
  localparam logic [7:0] DIGIT_7  = 8'h37;

  typedef enum logic [2:0] {
    K_HDR   = 3'd0,
    K_OK    = 3'd1,
    K_DATA  = 3'd2,
    K_PAD   = 3'd3,
    K_END   = 3'd4,
    K_CSUM  = 3'd5,
    K_TRUNC = 3'd6,
    K_IDLE  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_STOP   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    SCAN_SKIP = 2'd0,
    SCAN_DIGITS = 2'd1,
    SCAN_DONE = 2'd2
  } scan_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        data_byte;
    logic [SIZE_W-1:0] entry_size;
    logic [7:0]        hdr_type;
  } result_t;

  function automatic logic is_octal(input logic [7:0] b);
    return (b >= DIGIT_0) && (b <= DIGIT_7);
  endfunction

endpackage

/* hw/rtl/tar_stream_deframer.sv */
// Tar stream deframer: splits a tar byte stream into 512-byte header and data
// blocks, one byte per transaction in and one result per byte out. Headers are
// summed with the checksum field read as spaces, the octal size and checksum
// fields are parsed, and the last header byte reports header ok, end of archive
// or checksum error; data bytes are classed as file data or padding. Early end of
// input reports truncated. After any of these stop reasons every byte returns
// idle until reset. The block takes one byte every cycle while its results are
// not stalled. A byte is taken into the input register; its result is formed by
// the sum, octal shift and byte counter update and is loaded into the result
// register, where it waits until it is taken. While the output stalls, the two
// registers fill and the input then stalls too.
`include "assert_macros.svh"
module tar_stream_deframer import tsd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        byte_in,
  input  logic              end_of_input,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        kind,
  output logic [7:0]        data_byte,
  output logic [SIZE_W-1:0] entry_size,
  output logic [7:0]        hdr_type
);

  logic     advance;
  logic     item_valid;
  in_item_t item;
  result_t  result;

  tsd_in_reg u_in_reg (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_in      (byte_in),
    .end_of_input (end_of_input),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  tsd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result     (result)
  );

  assign kind       = result.kind;
  assign data_byte  = result.data_byte;
  assign entry_size = result.entry_size;
  assign hdr_type   = result.hdr_type;

  `ASSERT_IMP(a_stall_only_full, in_stall, item_valid && out_valid && out_stall,
              "input stalled with room in the pipeline")
  `ASSERT_IMP(a_hdr_fields_on_ok, out_valid && (kind != K_OK),
              (entry_size == '0) && (hdr_type == '0), "header fields set outside header ok")
  `ASSERT_NXT(a_idle_after_stop,
              out_valid && !out_stall && ((kind == K_END) || (kind == K_CSUM) || (kind == K_TRUNC)),
              !out_valid || (kind == K_IDLE), "result after stop is not idle")

endmodule

/* hw/rtl/tsd_octal_field.sv */
// Octal text field scanner: skips leading non-digits, stops at the first non-digit.
module tsd_octal_field import tsd_pkg::*; #(
  parameter int unsigned WIDTH = CSUM_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             clear,
  input  logic [7:0]       char_in,
  output logic [WIDTH-1:0] value
);

  scan_t            scan, scan_next;
  logic [WIDTH-1:0] value_next;
  logic             digit;

  always_comb begin
    digit      = is_octal(char_in);
    scan_next  = scan;
    value_next = value;
    if (clear) begin
      scan_next  = SCAN_SKIP;
      value_next = '0;
    end else if (en) begin
      unique case (scan)
        SCAN_SKIP: begin
          if (digit) begin
            scan_next  = SCAN_DIGITS;
            value_next = WIDTH'(char_in[2:0]);
          end
        end
        SCAN_DIGITS: begin
          // shift in one octal digit; the top bits drop off
          if (digit) value_next = {value[WIDTH-4:0], char_in[2:0]};
          else scan_next = SCAN_DONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan  <= SCAN_SKIP;
      value <= '0;
    end else begin
      scan  <= scan_next;
      value <= value_next;
    end
  end

endmodule

/* hw/rtl/tsd_in_reg.sv */
// Input register stage with stall back to the source.
module tsd_in_reg import tsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] byte_in,
  input  logic       end_of_input,
  input  logic       advance,
  output logic       item_valid,
  output in_item_t   item
);

  logic load;

  assign load     = !item_valid || advance;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item.data <= byte_in;
      item.eoi  <= end_of_input;
    end
  end

endmodule

/* hw/rtl/tsd_parser.sv */
// Block framing, header checks and data classing, with the result register.
module tsd_parser import tsd_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  input  in_item_t item,
  output logic     advance,
  output logic     out_valid,
  input  logic     out_stall,
  output result_t  result
);

  logic [OFFSET_W-1:0]   offset, offset_next;
  phase_t                phase, phase_next;
  logic [BYTE_SUM_W-1:0] byte_sum, byte_sum_next;
  logic                  all_zero, all_zero_next;
  logic [7:0]            type_byte, type_byte_next;
  logic [SIZE_W-1:0]     bytes_left, bytes_left_next;
  logic [SIZE_W-1:0]     size_value;
  logic [CSUM_W-1:0]     stored_sum;
  logic [SIZE_W-1:0]     eff_size;
  result_t               result_next;
  logic                  take, last, in_sum, in_size, hdr_clear;

  assign advance = !out_valid || !out_stall;
  assign take    = item_valid && advance;
  assign last    = (offset == BLOCK_LAST);
  assign in_sum  = (offset >= SUM_FIRST) && (offset <= SUM_LAST);
  assign in_size = (offset >= SIZE_FIRST) && (offset <= SIZE_LAST);
  assign eff_size = (type_byte == DIR_TYPE) ? '0 : size_value;

  tsd_octal_field #(.WIDTH(SIZE_W)) u_size (
    .clk     (clk),
    .rst     (rst),
    .en      (take && (phase == PH_HEADER) && in_size),
    .clear   (hdr_clear),
    .char_in (item.data),
    .value   (size_value)
  );

  tsd_octal_field #(.WIDTH(CSUM_W)) u_csum (
    .clk     (clk),
    .rst     (rst),
    .en      (take && (phase == PH_HEADER) && in_sum),
    .clear   (hdr_clear),
    .char_in (item.data),
    .value   (stored_sum)
  );

  always_comb begin
    offset_next     = offset + 1'b1;
    phase_next      = phase;
    byte_sum_next   = byte_sum;
    all_zero_next   = all_zero;
    type_byte_next  = type_byte;
    bytes_left_next = bytes_left;
    hdr_clear       = 1'b0;
    result_next     = '{kind: K_HDR, data_byte: item.data, entry_size: '0, hdr_type: '0};
    unique case (phase)
      PH_HEADER: begin
        byte_sum_next = byte_sum + BYTE_SUM_W'(in_sum ? SUM_FILL : item.data);
        all_zero_next = all_zero && (item.data == 8'h00);
        if (offset == TYPE_AT) type_byte_next = item.data;
        if (last) begin
          if (all_zero_next) begin
            result_next.kind = K_END;
            phase_next       = PH_STOP;
          end else if (CSUM_W'(byte_sum_next) != stored_sum) begin
            result_next.kind = K_CSUM;
            phase_next       = PH_STOP;
          end else if (item.eoi) begin
            result_next.kind = K_TRUNC;
            phase_next       = PH_STOP;
          end else begin
            result_next.kind       = K_OK;
            result_next.entry_size = eff_size;
            result_next.hdr_type   = type_byte;
            bytes_left_next        = eff_size;
            phase_next             = (eff_size != '0) ? PH_DATA : PH_HEADER;
            hdr_clear              = take;
            byte_sum_next          = '0;
            all_zero_next          = 1'b1;
            type_byte_next         = '0;
          end
        end else if (item.eoi) begin
          result_next.kind = K_TRUNC;
          phase_next       = PH_STOP;
        end
      end
      PH_DATA: begin
        if (bytes_left != '0) begin
          result_next.kind = K_DATA;
          bytes_left_next  = bytes_left - 1'b1;
        end else begin
          result_next.kind = K_PAD;
        end
        if (item.eoi) begin
          result_next.kind = K_TRUNC;
          phase_next       = PH_STOP;
        end else if (last && (bytes_left_next == '0)) begin
          phase_next = PH_HEADER;
        end
      end
      default: begin
        // stopped: idle results until reset
        result_next = '{kind: K_IDLE, data_byte: '0, entry_size: '0, hdr_type: '0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset     <= '0;
      phase      <= PH_HEADER;
      byte_sum   <= '0;
      all_zero   <= 1'b1;
      type_byte  <= '0;
      bytes_left <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (take) begin
        offset     <= offset_next;
        phase      <= phase_next;
        byte_sum   <= byte_sum_next;
        all_zero   <= all_zero_next;
        type_byte  <= type_byte_next;
        bytes_left <= bytes_left_next;
      end
      if (advance) out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) result <= result_next;
  end

endmodule
